>>> rtl/erm_pkg.sv
`timescale 1ns / 1ps
package erm_pkg;

  localparam int AngleW = 16;
  localparam int RotW   = 16;
  localparam int TrigW  = 22;  // q20 sine or cosine, with headroom
  localparam int CordW  = 34;  // q30 cordic x, y and z
  localparam int AtanEntries = 24;

  localparam logic signed [CordW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [CordW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [CordW-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [17:0]      Q14_ONE     = 18'sd16384;

  localparam logic [29:0] ATAN_Q30 [AtanEntries] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  typedef struct packed {
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [RotW-1:0] rot_r0_c0;
    logic signed [RotW-1:0] rot_r0_c1;
    logic signed [RotW-1:0] rot_r0_c2;
    logic signed [RotW-1:0] rot_r1_c0;
    logic signed [RotW-1:0] rot_r1_c1;
    logic signed [RotW-1:0] rot_r1_c2;
    logic signed [RotW-1:0] rot_r2_c0;
    logic signed [RotW-1:0] rot_r2_c1;
    logic signed [RotW-1:0] rot_r2_c2;
  } rot_t;

  typedef struct packed {
    logic signed [TrigW-1:0] sx;
    logic signed [TrigW-1:0] cx;
    logic signed [TrigW-1:0] sy;
    logic signed [TrigW-1:0] cy;
    logic signed [TrigW-1:0] sz;
    logic signed [TrigW-1:0] cz;
  } trig_t;

endpackage

>>> rtl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// zyx euler angles (roll, pitch, yaw in q3.13 radians) to the 3x3 rotation
// matrix rz*ry*rx in q1.14, each entry rounded and clamped to plus or minus
// one. a single-axis rotation is the same word with the other angles zero.
// one angle word enters per cycle unless an output stall backs up to the input.
// the stages (at most 24 of them cordic stages) are one fold stage, one stage per
// cordic iteration, a rounding stage, then five product, sum, round and saturate
// stages, the last of which is the output register. each stage has its own
// valid bit and takes a new word whenever it is empty or its successor moves,
// so bubbles close up under a stall on the output side.
module euler_to_rotation_matrix import erm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    angle_valid,
  output logic    angle_ready,
  input  angles_t angle,
  output logic    rot_valid,
  input  logic    rot_ready,
  output rot_t    rot
);

  // sine / cosine word between the cordic and the matrix products
  logic  trig_valid;
  logic  trig_ready;
  trig_t trig;

  // three cordic lanes in lockstep
  erm_sincos #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_sincos (
    .clk        (clk),
    .rst        (rst),
    .angle_valid(angle_valid),
    .angle_ready(angle_ready),
    .angle      (angle),
    .trig_valid (trig_valid),
    .trig_ready (trig_ready),
    .trig       (trig)
  );

  // products formed exactly in q60, then rounded and saturated
  erm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .trig_valid(trig_valid),
    .trig_ready(trig_ready),
    .trig      (trig),
    .rot_valid (rot_valid),
    .rot_ready (rot_ready),
    .rot       (rot)
  );

endmodule

>>> rtl/erm_sincos.sv
`timescale 1ns / 1ps
module erm_sincos import erm_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    angle_valid,
  output logic    angle_ready,
  input  angles_t angle,
  output logic    trig_valid,
  input  logic    trig_ready,
  output trig_t   trig
);

  localparam int N = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

  // stage 0 holds the folded angle, stage k the result of iteration k-1,
  // stage N+1 the rounded q20 values
  logic [N+1:0] vld;
  logic [N+2:0] rdy;
  logic signed [CordW-1:0] x [0:N][3];
  logic signed [CordW-1:0] y [0:N][3];
  logic signed [CordW-1:0] z [0:N][3];
  logic                    flip [0:N][3];
  logic signed [AngleW-1:0] raw [3];
  logic signed [TrigW-1:0] s_out [3];
  logic signed [TrigW-1:0] c_out [3];

  assign raw[0] = angle.roll_angle;
  assign raw[1] = angle.pitch_angle;
  assign raw[2] = angle.yaw_angle;

  assign rdy[N+2] = trig_ready;
  genvar k, l;
  generate
    for (k = 0; k <= N + 1; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  endgenerate
  assign angle_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= angle_valid;
      end
      for (int j = 1; j <= N + 1; j++) begin
        if (rdy[j]) begin
          vld[j] <= vld[j-1];
        end
      end
    end
  end

  generate
    for (l = 0; l < 3; l++) begin : g_lane
      logic signed [CordW-1:0] z_in;
      assign z_in = CordW'(raw[l]) <<< 17;

      // fold into [-pi/2, pi/2]
      always_ff @(posedge clk) begin
        if (rdy[0]) begin
          x[0][l] <= Q30_GAIN;
          y[0][l] <= '0;
          if (z_in > Q30_HALF_PI) begin
            z[0][l]    <= z_in - Q30_PI;
            flip[0][l] <= 1'b1;
          end else if (z_in < -Q30_HALF_PI) begin
            z[0][l]    <= z_in + Q30_PI;
            flip[0][l] <= 1'b1;
          end else begin
            z[0][l]    <= z_in;
            flip[0][l] <= 1'b0;
          end
        end
      end

      for (k = 1; k <= N; k++) begin : g_iter
        logic signed [CordW-1:0] dx, dy, da;
        assign dx = y[k-1][l] >>> (k - 1);
        assign dy = x[k-1][l] >>> (k - 1);
        assign da = CordW'(ATAN_Q30[k-1]);
        always_ff @(posedge clk) begin
          if (rdy[k]) begin
            flip[k][l] <= flip[k-1][l];
            if (!z[k-1][l][CordW-1]) begin
              x[k][l] <= x[k-1][l] - dx;
              y[k][l] <= y[k-1][l] + dy;
              z[k][l] <= z[k-1][l] - da;
            end else begin
              x[k][l] <= x[k-1][l] + dx;
              y[k][l] <= y[k-1][l] - dy;
              z[k][l] <= z[k-1][l] + da;
            end
          end
        end
      end

      // undo the fold, round q30 to q20
      logic signed [CordW-1:0] xf, yf, xr, yr;
      assign xf = flip[N][l] ? -x[N][l] : x[N][l];
      assign yf = flip[N][l] ? -y[N][l] : y[N][l];
      assign xr = (xf + CordW'(512)) >>> 10;
      assign yr = (yf + CordW'(512)) >>> 10;
      always_ff @(posedge clk) begin
        if (rdy[N+1]) begin
          s_out[l] <= yr[TrigW-1:0];
          c_out[l] <= xr[TrigW-1:0];
        end
      end
    end
  endgenerate

  assign trig_valid = vld[N+1];
  assign trig.sx = s_out[0];
  assign trig.cx = c_out[0];
  assign trig.sy = s_out[1];
  assign trig.cy = c_out[1];
  assign trig.sz = s_out[2];
  assign trig.cz = c_out[2];

endmodule

>>> rtl/erm_matrix.sv
`timescale 1ns / 1ps
module erm_matrix import erm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  trig_valid,
  output logic  trig_ready,
  input  trig_t trig,
  output logic  rot_valid,
  input  logic  rot_ready,
  output rot_t  rot
);

  localparam int PW = 2 * TrigW;

  logic [5:1] vld;
  logic [6:1] rdy;

  // stage 1: pair products
  logic signed [PW-1:0] czsy, szsy, szcx, czsx, szsx, czcx, czcy, szcy, cysx, cycx;
  logic signed [TrigW-1:0] sx1, cx1, sy1;
  // stage 2: split triple products
  logic signed [PW-1:0]   ph [4];
  logic signed [PW:0]     pl [4];
  logic signed [PW-1:0] szcx2, czsx2, szsx2, czcx2, czcy2, szcy2, cysx2, cycx2;
  logic signed [TrigW-1:0] sy2;
  // stage 3: q60 entries, stage 4: rounded q14
  logic signed [63:0] v [9];
  logic signed [17:0] r [9];
  logic signed [RotW-1:0] q [9];

  function automatic logic signed [63:0] ext(input logic signed [PW:0] a);
    return 64'(a);
  endfunction

  function automatic logic signed [RotW-1:0] sat(input logic signed [17:0] a);
    if (a > Q14_ONE) return RotW'(Q14_ONE);
    if (a < -Q14_ONE) return RotW'(-Q14_ONE);
    return a[RotW-1:0];
  endfunction

  assign rdy[6] = rot_ready;
  genvar k;
  generate
    for (k = 1; k <= 5; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  endgenerate
  assign trig_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= trig_valid;
      end
      for (int j = 2; j <= 5; j++) begin
        if (rdy[j]) begin
          vld[j] <= vld[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      czsy <= trig.cz * trig.sy;
      szsy <= trig.sz * trig.sy;
      szcx <= trig.sz * trig.cx;
      czsx <= trig.cz * trig.sx;
      szsx <= trig.sz * trig.sx;
      czcx <= trig.cz * trig.cx;
      czcy <= trig.cz * trig.cy;
      szcy <= trig.sz * trig.cy;
      cysx <= trig.cy * trig.sx;
      cycx <= trig.cy * trig.cx;
      sx1  <= trig.sx;
      cx1  <= trig.cx;
      sy1  <= trig.sy;
    end
  end

  // triple products cut into high and low halves of the pair product
  logic signed [PW-1:0]   pp [4];
  logic signed [TrigW-1:0] ps [4];
  assign pp[0] = czsy; assign ps[0] = sx1;
  assign pp[1] = czsy; assign ps[1] = cx1;
  assign pp[2] = szsy; assign ps[2] = sx1;
  assign pp[3] = szsy; assign ps[3] = cx1;

  generate
    for (k = 0; k < 4; k++) begin : g_split
      logic signed [TrigW-1:0] hi;
      logic signed [TrigW:0]   lo;
      assign hi = pp[k][PW-1:TrigW];
      assign lo = {1'b0, pp[k][TrigW-1:0]};
      always_ff @(posedge clk) begin
        if (rdy[2]) begin
          ph[k] <= hi * ps[k];
          pl[k] <= lo * ps[k];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      szcx2 <= szcx; czsx2 <= czsx; szsx2 <= szsx; czcx2 <= czcx;
      czcy2 <= czcy; szcy2 <= szcy; cysx2 <= cysx; cycx2 <= cycx;
      sy2   <= sy1;
    end
  end

  logic signed [63:0] t [4];
  generate
    for (k = 0; k < 4; k++) begin : g_tri
      assign t[k] = (ext((PW+1)'(ph[k])) <<< TrigW) + ext(pl[k]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      v[0] <= ext((PW+1)'(czcy2)) <<< 20;
      v[1] <= t[0] - (ext((PW+1)'(szcx2)) <<< 20);
      v[2] <= t[1] + (ext((PW+1)'(szsx2)) <<< 20);
      v[3] <= ext((PW+1)'(szcy2)) <<< 20;
      v[4] <= t[2] + (ext((PW+1)'(czcx2)) <<< 20);
      v[5] <= t[3] - (ext((PW+1)'(czsx2)) <<< 20);
      v[6] <= -(ext((PW+1)'(sy2)) <<< 40);
      v[7] <= ext((PW+1)'(cysx2)) <<< 20;
      v[8] <= ext((PW+1)'(cycx2)) <<< 20;
    end
  end

  generate
    for (k = 0; k < 9; k++) begin : g_out
      logic signed [63:0] vr;
      assign vr = (v[k] + (64'sd1 <<< 45)) >>> 46;
      always_ff @(posedge clk) begin
        if (rdy[4]) begin
          r[k] <= vr[17:0];
        end
        if (rdy[5]) begin
          q[k] <= sat(r[k]);
        end
      end
    end
  endgenerate

  assign rot_valid     = vld[5];
  assign rot.rot_r0_c0 = q[0];
  assign rot.rot_r0_c1 = q[1];
  assign rot.rot_r0_c2 = q[2];
  assign rot.rot_r1_c0 = q[3];
  assign rot.rot_r1_c1 = q[4];
  assign rot.rot_r1_c2 = q[5];
  assign rot.rot_r2_c0 = q[6];
  assign rot.rot_r2_c1 = q[7];
  assign rot.rot_r2_c2 = q[8];

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import erm_pkg::*;

  localparam int Steps = 16;
  localparam int NumRandom = 1500;
  // pipeline depth of the rtl, plus margin for drain
  localparam int Drain = Steps + 7 + 40;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    angle_valid = 1'b0;
  logic    angle_ready;
  angles_t angle = '0;
  logic    rot_valid;
  logic    rot_ready = 1'b0;
  rot_t    rot;

  angles_t pending_angles[$];
  rot_t    expected_rots[$];
  int      words_in = 0;
  int      words_out = 0;
  int      errors = 0;
  int      folded = 0;
  bit      stim_done = 1'b0;

  euler_to_rotation_matrix #(.CORDIC_STEPS(Steps)) uut (
    .clk(clk), .rst(rst),
    .angle_valid(angle_valid), .angle_ready(angle_ready), .angle(angle),
    .rot_valid(rot_valid), .rot_ready(rot_ready), .rot(rot)
  );

  always #2 clk = ~clk;

  // q3.13 angle to q20 sine and cosine via the same cordic as the block
  function automatic void sin_cos(input logic signed [15:0] a,
                                  output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(a) * 131072;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > longint'(Q30_HALF_PI)) begin
      z -= longint'(Q30_PI);
      flip = 1'b1;
    end else if (z < -longint'(Q30_HALF_PI)) begin
      z += longint'(Q30_PI);
      flip = 1'b1;
    end
    for (int i = 0; i < Steps && i < AtanEntries; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_Q30[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = (y + 512) >>> 10;
    c = (x + 512) >>> 10;
  endfunction

  // q60 value rounded half up to q14 and clamped to plus or minus one
  function automatic logic signed [15:0] q60_to_q14(longint v);
    longint r;
    r = (v + (longint'(1) <<< 45)) >>> 46;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic rot_t rotation_of(angles_t a);
    longint sx, cx, sy, cy, sz, cz;
    rot_t m;
    sin_cos(a.roll_angle, sx, cx);
    sin_cos(a.pitch_angle, sy, cy);
    sin_cos(a.yaw_angle, sz, cz);
    m.rot_r0_c0 = q60_to_q14(cz * cy * 1048576);
    m.rot_r0_c1 = q60_to_q14(cz * sy * sx - sz * cx * 1048576);
    m.rot_r0_c2 = q60_to_q14(cz * sy * cx + sz * sx * 1048576);
    m.rot_r1_c0 = q60_to_q14(sz * cy * 1048576);
    m.rot_r1_c1 = q60_to_q14(sz * sy * sx + cz * cx * 1048576);
    m.rot_r1_c2 = q60_to_q14(sz * sy * cx - cz * sx * 1048576);
    m.rot_r2_c0 = q60_to_q14(-sy * 64'sd1099511627776);
    m.rot_r2_c1 = q60_to_q14(cy * sx * 1048576);
    m.rot_r2_c2 = q60_to_q14(cy * cx * 1048576);
    return m;
  endfunction

  // idle percentages: receiver-light phase, sender-light phase, then none
  function automatic int send_idle_pct();
    if (words_in < 500) return 9;
    if (words_in < 1000) return 81;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (words_in < 500) return 81;
    if (words_in < 1000) return 9;
    return 0;
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(25736)) - 12868);   // no fold but at +-12868
      2: return 16'($signed($urandom_range(60)) + 12838);      // near +pi/2
      default: return 16'(-$signed($urandom_range(60)) - 12838); // near -pi/2
    endcase
  endfunction

  function automatic angles_t mk(int r, int p, int y);
    angles_t a;
    a.roll_angle = 16'(r);
    a.pitch_angle = 16'(p);
    a.yaw_angle = 16'(y);
    return a;
  endfunction

  // sender: a new word is offered once the previous one has gone
  bit angle_taken = 1'b0;
  always @(posedge clk) angle_taken <= angle_valid && angle_ready;

  always @(negedge clk) begin
    if (!rst && (!angle_valid || angle_taken)) begin
      if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        angle <= pending_angles.pop_front();
        angle_valid <= 1'b1;
      end else begin
        angle_valid <= 1'b0;
      end
    end
    if (!rst) rot_ready <= ($urandom_range(99) >= recv_idle_pct());
  end

  // accepted angle words feed the predictor; results are checked in order
  always @(posedge clk) begin
    if (!rst && angle_valid && angle_ready) begin
      expected_rots.push_back(rotation_of(angle));
      words_in++;
      if (angle.roll_angle > 12867 || angle.roll_angle < -12867) folded++;
    end
    if (!rst && rot_valid && rot_ready) begin
      if (expected_rots.size() == 0) begin
        $display("%0t: unexpected rotation word %h", $time, rot);
        errors++;
      end else begin
        rot_t want;
        logic [143:0] wv, gv;
        want = expected_rots.pop_front();
        wv = want;
        gv = rot;
        for (int i = 0; i < 9; i++)
          if (wv[143-16*i -: 16] !== gv[143-16*i -: 16]) begin
            $display("%0t: entry r%0d_c%0d expected %0d got %0d", $time, i / 3, i % 3,
                     $signed(wv[143-16*i -: 16]), $signed(gv[143-16*i -: 16]));
            errors++;
          end
      end
      words_out++;
    end
  end

  initial begin
    // directed: zero, axis extremes, fold boundaries at pi/2 and pi
    pending_angles.push_back(mk(0, 0, 0));
    pending_angles.push_back(mk(32767, 0, 0));
    pending_angles.push_back(mk(-32768, 0, 0));
    pending_angles.push_back(mk(0, 32767, 0));
    pending_angles.push_back(mk(0, -32768, 0));
    pending_angles.push_back(mk(0, 0, 32767));
    pending_angles.push_back(mk(0, 0, -32768));
    pending_angles.push_back(mk(12867, 12868, -12867));
    pending_angles.push_back(mk(-12868, -12867, 12868));
    pending_angles.push_back(mk(25736, -25736, 25735));
    pending_angles.push_back(mk(-25735, 25735, -25736));
    pending_angles.push_back(mk(12868, 12868, 12868));
    pending_angles.push_back(mk(-32768, -32768, -32768));
    pending_angles.push_back(mk(32767, 32767, 32767));
    pending_angles.push_back(mk(6434, -6434, 6434));
    pending_angles.push_back(mk(1, -1, 1));
    for (int i = 0; i < NumRandom; i++)
      pending_angles.push_back(mk(rand_angle(), rand_angle(), rand_angle()));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_angles.size() == 0 && !angle_valid && expected_rots.size() == 0);
    repeat (Drain) @(posedge clk);
    $display("covered %0d angle words, %0d matrices checked, %0d with folded roll",
             words_in, words_out, folded);
    if (errors == 0 && expected_rots.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", expected_rots.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
